>>> rtl/core/ppq_pkg.sv
// Shared types and constants for the priority process queue.
// Holds the entry, command and control structs used by the cell chain and the top level.
// No dependencies.
package ppq_pkg;

  localparam int QW = 2;              // queue selector width
  localparam int PW = 8;              // priority width
  localparam int IW = 5;              // process id width
  localparam int DEPTH_DEF = 32;
  localparam int NUM_QUEUES_DEF = 4;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_PEEK    = 2'd1,
    K_RM_HEAD = 2'd2,
    K_RM_ID   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2,
    STAT_DUP  = 2'd3
  } status_t;

  typedef struct packed {
    logic          valid;
    logic [QW-1:0] queue;
    logic [PW-1:0] prio;
    logic [IW-1:0] id;
  } entry_t;

  typedef struct packed {
    kind_t         kind;
    logic [QW-1:0] queue;
    logic [IW-1:0] id;
    logic [PW-1:0] prio;
  } cmd_t;

  // Broadcast to every cell in the update cycle.
  typedef struct packed {
    logic apply;
    logic ins_ok;
    logic rm_ok;
    cmd_t cmd;
  } ctl_t;

endpackage

>>> rtl/core/ppq_cell.sv
// One cell of the sorted queue chain: holds one entry and its match flags.
// Shifts toward either neighbor on insert or removal. Depends on ppq_pkg.
module ppq_cell (
  input  logic            clk,
  input  logic            rst,
  input  ppq_pkg::cmd_t   cmd_in,
  input  logic            load,
  input  ppq_pkg::ctl_t   ctl,
  input  ppq_pkg::entry_t left,
  input  ppq_pkg::entry_t right,
  output ppq_pkg::entry_t entry,
  input  logic            before_in,
  output logic            before_out,
  output logic            dup,
  output logic            qmatch,
  output logic            first
);
  import ppq_pkg::*;

  entry_t ent;
  logic   f_dup;
  logic   f_qm;
  logic   f_ins;
  logic   f_idq;
  logic   hit;
  logic   reach;
  logic   in_q;
  entry_t fresh;

  assign in_q = ent.valid && (ent.queue == cmd_in.queue);

  // Compare against the incoming transaction as it is accepted.
  always_ff @(posedge clk) begin
    if (load) begin
      f_dup <= ent.valid && (ent.id == cmd_in.id);
      f_qm  <= in_q;
      f_ins <= (in_q && (ent.prio < cmd_in.prio)) || !ent.valid;
      f_idq <= in_q && (ent.id == cmd_in.id);
    end
  end

  always_comb begin
    case (ctl.cmd.kind)
      K_INSERT: hit = f_ins;
      K_RM_ID:  hit = f_idq;
      default:  hit = f_qm;
    endcase
  end

  assign reach      = before_in | hit;
  assign before_out = reach;
  assign first      = hit & ~before_in;
  assign dup        = f_dup;
  assign qmatch     = f_qm;
  assign entry      = ent;

  assign fresh = '{valid: 1'b1, queue: ctl.cmd.queue, prio: ctl.cmd.prio, id: ctl.cmd.id};

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctl.apply && reach) begin
      if (ctl.ins_ok) begin
        ent <= first ? fresh : left;
      end else if (ctl.rm_ok) begin
        ent <= right;
      end
    end
  end

endmodule

>>> rtl/core/priority_process_queue.sv
// Top level of the priority process queue: stream ports, sequencer and cell chain.
// Instantiates DEPTH ppq_cell cells; depends on ppq_pkg.
//
//  channel | dir | fields (low bit up)                                     | handshake
//  s_*     | in  | tuser: kind; tdata: queue_select, process_id, priority  | s_tvalid/s_tready
//  m_*     | out | tuser: status; tdata: result_id, queue_empty            | m_tvalid/m_tready
//
// Each transaction is latched as it is accepted, which also registers every cell's compare
// flags; the update state then resolves the first hit along the cell chain and shifts the chain.
// A new transaction is taken while a result waits in the output register; the update
// cycle holds only while that register is still full.
// Reset (rst, synchronous) clears all cell valid bits and the sequencer; no clearing pass.
module priority_process_queue #(
  parameter int DEPTH      = ppq_pkg::DEPTH_DEF,
  parameter int NUM_QUEUES = ppq_pkg::NUM_QUEUES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // queue_select[1:0], process_id[6:2], priority_req[14:7]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // result_id[4:0], queue_empty[5]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import ppq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t        state;
  cmd_t          cmd_in;
  cmd_t          cmd;
  ctl_t          ctl;
  logic          accept;
  logic          out_free;
  logic          dup_any;
  logic          full;
  logic          hit_any;
  logic          ins_ok;
  logic          rm_ok;
  logic          others;
  logic [IW-1:0] head_id;
  logic [IW-1:0] rid;
  status_t       status;

  entry_t             entries [DEPTH];
  logic [DEPTH:0]     chain;
  logic [DEPTH-1:0]   dup_v;
  logic [DEPTH-1:0]   qm_v;
  logic [DEPTH-1:0]   first_v;
  logic [DEPTH-1:0]   valid_vec;

  // Fold an out-of-range selector back into the queue range.
  function automatic logic [QW-1:0] fold_queue(input logic [QW-1:0] sel);
    logic [QW-1:0] q;
    q = sel;
    for (int i = 0; i < (1 << QW); i++) begin
      if (int'(q) >= NUM_QUEUES) q = q - QW'(NUM_QUEUES);
    end
    return q;
  endfunction

  assign cmd_in.kind  = kind_t'(s_tuser);
  assign cmd_in.queue = fold_queue(s_tdata[1:0]);
  assign cmd_in.id    = s_tdata[6:2];
  assign cmd_in.prio  = s_tdata[14:7];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) state <= ST_EVAL;
        ST_EVAL: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cmd <= cmd_in;
  end

  assign chain[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      entry_t lft;
      entry_t rgt;
      if (gi == 0) begin : g_first
        assign lft = '0;
      end else begin : g_mid_l
        assign lft = entries[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign rgt = '0;
      end else begin : g_mid_r
        assign rgt = entries[gi+1];
      end
      ppq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd_in     (cmd_in),
        .load       (accept),
        .ctl        (ctl),
        .left       (lft),
        .right      (rgt),
        .entry      (entries[gi]),
        .before_in  (chain[gi]),
        .before_out (chain[gi+1]),
        .dup        (dup_v[gi]),
        .qmatch     (qm_v[gi]),
        .first      (first_v[gi])
      );
      assign valid_vec[gi] = entries[gi].valid;
    end
  endgenerate

  assign dup_any = |dup_v;
  assign full    = valid_vec[DEPTH-1];
  assign hit_any = chain[DEPTH];
  assign ins_ok  = (cmd.kind == K_INSERT) && !dup_any && !full;
  assign rm_ok   = ((cmd.kind == K_RM_HEAD) || (cmd.kind == K_RM_ID)) && hit_any;

  assign ctl.apply  = (state == ST_EVAL) && out_free;
  assign ctl.ins_ok = ins_ok;
  assign ctl.rm_ok  = rm_ok;
  assign ctl.cmd    = cmd;

  always_comb begin
    head_id = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_v[i]) head_id = head_id | entries[i].id;
    end
  end

  // Queue still holds an entry after the operation unless the only one is removed.
  assign others = |(qm_v & ~(first_v & {DEPTH{rm_ok}}));

  always_comb begin
    status = STAT_MISS;
    rid    = '0;
    case (cmd.kind)
      K_INSERT: begin
        if (dup_any)   status = STAT_DUP;
        else if (full) status = STAT_FULL;
        else           status = STAT_OK;
      end
      K_RM_ID: begin
        if (hit_any) begin
          status = STAT_OK;
          rid    = cmd.id;
        end
      end
      default: begin
        if (hit_any) begin
          status = STAT_OK;
          rid    = head_id;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.apply) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      m_tuser <= status;
      m_tdata <= {2'b00, !(ins_ok || others), rid};
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("transaction accepted during update cycle");

  a_result_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_EVAL))
    else $error("result produced outside update cycle");

  a_chain_packed: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("cell chain not packed");

  a_rid_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata[IW-1:0] == '0))
    else $error("nonzero id on failed operation");

endmodule
